// File: design/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int QW        = 16;        // quaternion component width
  localparam int PW        = 2 * QW;    // product width
  localparam int OPW       = PW + 1;    // atan2 operand width
  localparam int CW        = OPW + 3;   // CORDIC datapath width, covers gain
  localparam int ZW        = 28;        // angle accumulator, units of 2^-24 rad
  localparam int AW        = 16;        // output angle width, Q2.13
  localparam int PITCH_W   = 15;
  localparam int SQ_STAGES = 30;        // result bits of the square root
  localparam int SQ_W      = 2 * SQ_STAGES;
  localparam int PMAG_W    = 29;        // |P| below 2^29 when not clamped
  localparam int PP_W      = 2 * PMAG_W;
  localparam int RAD_W     = PP_W + 1;

  localparam int ANG_PI      = 52707179;
  localparam int OUT_PI      = 25736;
  localparam int OUT_HALF_PI = 12868;
  localparam int RND_HALF    = 1024;
  localparam int RND_SHIFT   = 11;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [AW-1:0]      yaw_angle;
    logic signed [AW-1:0]      roll_angle;
    logic                      pitch_clamped;
  } euler_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:    a = ZW'(13176795);
      5'd1:    a = ZW'(7778716);
      5'd2:    a = ZW'(4110060);
      5'd3:    a = ZW'(2086331);
      5'd4:    a = ZW'(1047214);
      5'd5:    a = ZW'(524117);
      5'd6:    a = ZW'(262123);
      5'd7:    a = ZW'(131069);
      5'd8:    a = ZW'(65536);
      5'd9:    a = ZW'(32768);
      5'd10:   a = ZW'(16384);
      5'd11:   a = ZW'(8192);
      5'd12:   a = ZW'(4096);
      5'd13:   a = ZW'(2048);
      5'd14:   a = ZW'(1024);
      5'd15:   a = ZW'(512);
      5'd16:   a = ZW'(256);
      5'd17:   a = ZW'(128);
      5'd18:   a = ZW'(64);
      5'd19:   a = ZW'(32);
      5'd20:   a = ZW'(16);
      5'd21:   a = ZW'(8);
      5'd22:   a = ZW'(4);
      5'd23:   a = ZW'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/q2e_delay.sv
`timescale 1ns / 1ps
module q2e_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q  [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] valid_d;

  // shift valid in at the bottom, advance toward the top
  if (DEPTH > 1) begin : g_multi
    assign valid_d = {valid_q[DEPTH-2:0], valid_i};
  end else begin : g_single
    assign valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int k = 1; k < DEPTH; k++) begin
      data_q[k] <= data_q[k-1];
    end
  end

  assign valid_o = valid_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];

endmodule

// File: design/q2e_isqrt.sv
`timescale 1ns / 1ps
module q2e_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [q2e_pkg::RAD_W-1:0]      rad_i,
  output logic                           valid_o,
  output logic [q2e_pkg::SQ_STAGES-1:0]  root_o
);
  import q2e_pkg::*;

  logic [SQ_W-1:0]      rem_q  [SQ_STAGES];
  logic [SQ_W-1:0]      root_q [SQ_STAGES];
  logic [SQ_STAGES-1:0] valid_q;
  logic [SQ_STAGES-1:0] valid_d;

  assign valid_d = {valid_q[SQ_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // one result bit per stage, most significant first
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STAGES - 1 - j));
    logic [SQ_W-1:0] rem_c, root_c, trial, rem_d, root_d;

    if (j == 0) begin : g_first
      assign rem_c  = SQ_W'(rad_i);
      assign root_c = '0;
    end else begin : g_next
      assign rem_c  = rem_q[j-1];
      assign root_c = root_q[j-1];
    end

    assign trial = root_c + BIT;

    always_comb begin
      if (rem_c >= trial) begin
        rem_d  = rem_c - trial;
        root_d = (root_c >> 1) + BIT;
      end else begin
        rem_d  = rem_c;
        root_d = root_c >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= rem_d;
      root_q[j] <= root_d;
    end
  end

  assign valid_o = valid_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1][SQ_STAGES-1:0];

endmodule

// File: design/q2e_cordic.sv
`timescale 1ns / 1ps
module q2e_cordic #(
  parameter int STEPS = 16,
  parameter int LIM   = 25736
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [q2e_pkg::OPW-1:0]   y_i,
  input  logic signed [q2e_pkg::OPW-1:0]   x_i,
  output logic                             valid_o,
  output logic signed [q2e_pkg::AW-1:0]    angle_o
);
  import q2e_pkg::*;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic [STEPS+1:0]     valid_q;
  logic [STEPS+1:0]     valid_d;

  logic signed [CW-1:0] x_ext, y_ext, x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;
  logic signed [ZW-1:0] zr;
  logic signed [AW-1:0] angle_d;
  logic signed [AW-1:0] angle_q;

  assign valid_d = {valid_q[STEPS:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // fold the left half plane onto the right, start from +-pi
  assign x_ext = CW'(x_i);
  assign y_ext = CW'(y_i);

  always_comb begin
    if (x_i < 0) begin
      x0_d = -x_ext;
      y0_d = -y_ext;
      z0_d = (y_i >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
    end else begin
      x0_d = x_ext;
      y0_d = y_ext;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == 0) && (y_i == 0);
  end

  // one micro-rotation per stage, drive y toward zero
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_comb begin
      if (!y_q[i][CW-1]) begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + atan_step(5'(i));
      end else begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - atan_step(5'(i));
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      zero_q[i+1] <= zero_q[i];
    end
  end

  // round to Q2.13 and clamp
  assign zr = (z_q[STEPS] + ZW'(RND_HALF)) >>> RND_SHIFT;

  always_comb begin
    if (zero_q[STEPS]) begin
      angle_d = '0;
    end else if (zr > ZW'(LIM)) begin
      angle_d = AW'(LIM);
    end else if (zr < -ZW'(LIM)) begin
      angle_d = -AW'(LIM);
    end else begin
      angle_d = AW'(zr);
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign valid_o = valid_q[STEPS+1];
  assign angle_o = angle_q;

endmodule

// File: design/quaternion_to_euler_yxz_core.sv
`timescale 1ns / 1ps
// Quaternion (Q1.15) to y-x-z Euler angles (Q2.13 rad), fully pipelined. One
// beat may be started in every cycle and busy never rises; each beat's result
// appears on result_o with done_o high for one cycle, in start order, and cannot
// be held off. The pitch path is the longest: stages A to D for the products,
// the operands, P*P and the radicand, a 30-stage square root (one result bit
// per stage) for cos(pitch), and a CORDIC_STEPS + 2 stage vectoring CORDIC.
// Roll and yaw run their CORDICs early and wait in a delay line. When
// |2(wy - zx)| reaches one, pitch is forced to +-pi/2 and pitch_clamped is set.
// No state is kept between beats.
module quaternion_to_euler_yxz_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  q2e_pkg::quat_t   quat_i,
  output logic             done_o,
  output q2e_pkg::euler_t  result_o
);
  import q2e_pkg::*;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int SIDE_DLY   = 1 + SQ_STAGES;  // stage D plus the square root
  localparam int ANGLE_DLY  = 2 + SQ_STAGES;  // stages C, D plus the root
  localparam logic signed [OPW-1:0] UNIT29 = OPW'(1) << 29;
  localparam logic [RAD_W-1:0]      UNIT58 = RAD_W'(1) << 58;

  // Axis permutation: w = qw, x = qz, y = qx, z = qy.
  logic signed [QW-1:0] w, x, y, z;
  assign w = quat_i.quat_w;
  assign x = quat_i.quat_z;
  assign y = quat_i.quat_x;
  assign z = quat_i.quat_y;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage A: all products, one multiplier each.
  logic v_a_q, v_b_q, v_c_q, v_d_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;

  always_ff @(posedge clk_i) begin
    wx_q <= PW'(w) * PW'(x);
    yz_q <= PW'(y) * PW'(z);
    xx_q <= PW'(x) * PW'(x);
    yy_q <= PW'(y) * PW'(y);
    wz_q <= PW'(w) * PW'(z);
    xy_q <= PW'(x) * PW'(y);
    zz_q <= PW'(z) * PW'(z);
    wy_q <= PW'(w) * PW'(y);
    zx_q <= PW'(z) * PW'(x);
  end

  // Stage B: atan2 operands and the pitch sine P, in units of 2^-29.
  logic signed [OPW-1:0] roll_y_d, roll_x_d, yaw_y_d, yaw_x_d, p_d, p_abs;
  logic signed [OPW-1:0] roll_y_q, roll_x_q, yaw_y_q, yaw_x_q;
  logic                  clamp_d, clamp_b_q, clamp_c_q;
  logic signed [SQ_STAGES-1:0] p_b_q, p_c_q;
  logic [PMAG_W-1:0]     pmag_b_q;
  logic [PP_W-1:0]       pp_c_q;
  logic [RAD_W-1:0]      rad_d_q;

  assign roll_y_d = OPW'(wx_q) + OPW'(yz_q);
  assign roll_x_d = UNIT29 - (OPW'(xx_q) + OPW'(yy_q));
  assign yaw_y_d  = OPW'(wz_q) + OPW'(xy_q);
  assign yaw_x_d  = UNIT29 - (OPW'(yy_q) + OPW'(zz_q));
  assign p_d      = OPW'(wy_q) - OPW'(zx_q);
  assign p_abs    = p_d[OPW-1] ? -p_d : p_d;
  assign clamp_d  = (p_d >= UNIT29) || (p_d <= -UNIT29);

  always_ff @(posedge clk_i) begin
    roll_y_q  <= roll_y_d;
    roll_x_q  <= roll_x_d;
    yaw_y_q   <= yaw_y_d;
    yaw_x_q   <= yaw_x_d;
    clamp_b_q <= clamp_d;
    // a clamped P does not fit; keep only its sign for the +-pi/2 choice
    p_b_q     <= clamp_d ? {p_d[OPW-1], (SQ_STAGES-1)'(0)} : p_d[SQ_STAGES-1:0];
    pmag_b_q  <= p_abs[PMAG_W-1:0];
  end

  // Stage C: P squared. Stage D: 1 - P^2, the radicand of cos(pitch).
  always_ff @(posedge clk_i) begin
    pp_c_q    <= PP_W'(pmag_b_q) * PP_W'(pmag_b_q);
    p_c_q     <= p_b_q;
    clamp_c_q <= clamp_b_q;
    rad_d_q   <= UNIT58 - RAD_W'(pp_c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      v_a_q <= accept;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
    end
  end

  // Roll and yaw: CORDIC straight from stage B, then hold for the pitch path.
  logic                 roll_v, yaw_v, ry_v;
  logic signed [AW-1:0] roll_ang, yaw_ang;
  logic [2*AW-1:0]      ry_dly;

  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(OUT_PI)) u_roll (
    .clk_i, .rst_ni,
    .valid_i (v_b_q),
    .y_i     (roll_y_q),
    .x_i     (roll_x_q),
    .valid_o (roll_v),
    .angle_o (roll_ang)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(OUT_PI)) u_yaw (
    .clk_i, .rst_ni,
    .valid_i (v_b_q),
    .y_i     (yaw_y_q),
    .x_i     (yaw_x_q),
    .valid_o (yaw_v),
    .angle_o (yaw_ang)
  );

  q2e_delay #(.WIDTH(2 * AW), .DEPTH(ANGLE_DLY)) u_ry_dly (
    .clk_i, .rst_ni,
    .valid_i (roll_v && yaw_v),
    .data_i  ({roll_ang, yaw_ang}),
    .valid_o (ry_v),
    .data_o  (ry_dly)
  );

  // Pitch: cos(pitch) by square root, P and the clamp flag ride alongside.
  logic                        sq_v, side_v, pitch_v, flag_v;
  logic [SQ_STAGES-1:0]        root;
  logic [SQ_STAGES:0]          side;
  logic signed [SQ_STAGES-1:0] p_side;
  logic [1:0]                  flag;
  logic signed [AW-1:0]        pitch_ang;
  logic signed [PITCH_W-1:0]   pitch_out;

  q2e_isqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v_d_q),
    .rad_i   (rad_d_q),
    .valid_o (sq_v),
    .root_o  (root)
  );

  q2e_delay #(.WIDTH(SQ_STAGES + 1), .DEPTH(SIDE_DLY)) u_side_dly (
    .clk_i, .rst_ni,
    .valid_i (v_c_q),
    .data_i  ({p_c_q, clamp_c_q}),
    .valid_o (side_v),
    .data_o  (side)
  );

  assign p_side = side[SQ_STAGES:1];

  q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(OUT_HALF_PI)) u_pitch (
    .clk_i, .rst_ni,
    .valid_i (sq_v),
    .y_i     (OPW'(p_side)),
    .x_i     ($signed(OPW'(root))),
    .valid_o (pitch_v),
    .angle_o (pitch_ang)
  );

  // carry {sign of P, clamp} across the pitch CORDIC
  q2e_delay #(.WIDTH(2), .DEPTH(CORDIC_LAT)) u_flag_dly (
    .clk_i, .rst_ni,
    .valid_i (side_v),
    .data_i  ({p_side[SQ_STAGES-1], side[0]}),
    .valid_o (flag_v),
    .data_o  (flag)
  );

  always_comb begin
    if (flag[0]) begin
      pitch_out = flag[1] ? -PITCH_W'(OUT_HALF_PI) : PITCH_W'(OUT_HALF_PI);
    end else begin
      pitch_out = pitch_ang[PITCH_W-1:0];
    end
  end

  assign done_o                 = flag_v;
  assign result_o.pitch_angle   = pitch_out;
  assign result_o.roll_angle    = ry_dly[2*AW-1:AW];
  assign result_o.yaw_angle     = ry_dly[AW-1:0];
  assign result_o.pitch_clamped = flag[0];

  a_ry_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ry_v == flag_v)
    else $error("roll/yaw beat out of step with pitch");

  a_side_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_v == sq_v)
    else $error("pitch side data out of step with square root");

  a_pitch_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pitch_v == flag_v)
    else $error("pitch CORDIC out of step with clamp flag");

  a_clamp_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.pitch_clamped |->
      (result_o.pitch_angle == PITCH_W'(OUT_HALF_PI)) ||
      (result_o.pitch_angle == -PITCH_W'(OUT_HALF_PI)))
    else $error("clamped pitch not at +-pi/2");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_d_q |-> $past(accept, 4))
    else $error("stage D valid without a start four cycles back");

endmodule

// File: tb/quaternion_to_euler_yxz_core_test.sv
`timescale 1ns / 1ps
module quaternion_to_euler_yxz_core_test;
  import q2e_pkg::*;

  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 36;

  localparam longint ANGLE_PI = 52707179;
  localparam longint UNIT     = 64'sd1 << 29;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  quat_t  quat_i;
  logic   done_o;
  euler_t result_o;

  euler_t euler_queue[$];
  int     fail_count;
  int     send_idle_pct;

  quaternion_to_euler_yxz_core #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .quat_i   (quat_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Floor shift, matching an arithmetic right shift on 64-bit values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= r + bit_w) begin
        n -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC atan2 in Q2.13, clamped to +-lim.
  function automatic longint angle_of(longint y, longint x, longint lim);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x += ys;
        y -= xs;
        ang += longint'(atan_step(5'(i)));
      end else begin
        x -= ys;
        y += xs;
        ang -= longint'(atan_step(5'(i)));
      end
    end
    ang = floor_shift(ang + RND_HALF, RND_SHIFT);
    if (ang > lim) ang = lim;
    if (ang < -lim) ang = -lim;
    return ang;
  endfunction

  // Predict the Euler angles of one quaternion (axes permuted: x=qz, y=qx, z=qy).
  function automatic euler_t euler_of(quat_t q);
    euler_t e;
    longint w, x, y, z, p;
    longint unsigned rest;
    w = longint'(q.quat_w);
    x = longint'(q.quat_z);
    y = longint'(q.quat_x);
    z = longint'(q.quat_y);
    e.roll_angle = AW'(angle_of(w * x + y * z, UNIT - (x * x + y * y), OUT_PI));
    e.yaw_angle  = AW'(angle_of(w * z + x * y, UNIT - (y * y + z * z), OUT_PI));
    p = w * y - z * x;
    if (p >= UNIT || p <= -UNIT) begin
      e.pitch_angle   = PITCH_W'((p > 0) ? OUT_HALF_PI : -OUT_HALF_PI);
      e.pitch_clamped = 1'b1;
    end else begin
      rest = (64'd1 << 58) - longint'(p * p);
      e.pitch_angle   = PITCH_W'(angle_of(p, longint'(int_sqrt(rest)), OUT_HALF_PI));
      e.pitch_clamped = 1'b0;
    end
    return e;
  endfunction

  // Send one beat: drop start while idling, hold it until accepted.
  task automatic send_quat(quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    quat_i <= q;
    do @(posedge clk_i); while (busy);
    euler_queue.push_back(euler_of(q));
    @(negedge clk_i);
  endtask

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = QW'(w);
    q.quat_x = QW'(x);
    q.quat_y = QW'(y);
    q.quat_z = QW'(z);
    return q;
  endfunction

  // Random quaternion: raw random bits, near gimbal lock, or uniform components within +-23170.
  function automatic quat_t random_quat();
    int mode;
    int a;
    int b;
    mode = $urandom_range(9);
    if (mode < 2) return quat_t'({$urandom, $urandom});
    if (mode < 4) begin
      // near gimbal lock: w ~ y for the permuted pitch term
      a = $urandom_range(23170 + 300, 23170 - 300);
      b = $urandom_range(600) - 300;
      return make_quat(a, a + b, $urandom_range(400) - 200, $urandom_range(400) - 200);
    end
    return make_quat($urandom_range(46340) - 23170, $urandom_range(46340) - 23170,
                     $urandom_range(46340) - 23170, $urandom_range(46340) - 23170);
  endfunction

  // Check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && done_o) begin
      if (euler_queue.size() == 0) begin
        $display("%0t: result with none expected: got %p", $time, result_o);
        fail_count++;
      end else begin
        want = euler_queue.pop_front();
        if (result_o.pitch_angle !== want.pitch_angle) begin
          $display("%0t: pitch_angle expected %0d got %0d", $time,
                   want.pitch_angle, result_o.pitch_angle);
          fail_count++;
        end
        if (result_o.yaw_angle !== want.yaw_angle) begin
          $display("%0t: yaw_angle expected %0d got %0d", $time,
                   want.yaw_angle, result_o.yaw_angle);
          fail_count++;
        end
        if (result_o.roll_angle !== want.roll_angle) begin
          $display("%0t: roll_angle expected %0d got %0d", $time,
                   want.roll_angle, result_o.roll_angle);
          fail_count++;
        end
        if (result_o.pitch_clamped !== want.pitch_clamped) begin
          $display("%0t: pitch_clamped expected %0b got %0b", $time,
                   want.pitch_clamped, result_o.pitch_clamped);
          fail_count++;
        end
      end
    end
  end

  // Extremes, zero vector, identity, near gimbal lock both signs.
  task automatic test_directed();
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(32767, 0, 0, 0));
    send_quat(make_quat(-32768, -32768, -32768, -32768));
    send_quat(make_quat(32767, 32767, 32767, 32767));
    send_quat(make_quat(-32768, 32767, -32768, 32767));
    send_quat(make_quat(23170, 23170, 0, 0));
    send_quat(make_quat(23170, -23170, 0, 0));
    send_quat(make_quat(0, 0, 23170, 23170));
    send_quat(make_quat(0, 0, 23170, -23170));
    send_quat(make_quat(0, 32767, 0, 0));
    send_quat(make_quat(0, 0, 32767, 0));
    send_quat(make_quat(0, 0, 0, 32767));
    send_quat(make_quat(0, 0, 0, -32768));
    send_quat(make_quat(-1, -1, -1, -1));
    send_quat(make_quat(1, 1, 1, 1));
    send_quat(make_quat(16384, 16384, 16384, 16384));
    send_quat(make_quat(16384, -16384, 16384, -16384));
    send_quat(make_quat(0, 0, 0, 1));
    send_quat(make_quat(0, -1, 0, 0));
  endtask

  task automatic test_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    repeat (count) send_quat(random_quat());
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    quat_i        = '0;
    fail_count    = 0;
    send_idle_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600, 12);
    test_random(600, 87);
    test_random(600, 0);
    start <= 1'b0;
    // drain: wait for outstanding results, bounded
    fork
      wait (euler_queue.size() == 0);
      repeat (LATENCY * 4) @(posedge clk_i);
    join_any
    disable fork;
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && euler_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
